>>> src/pclg_pkg.sv
// Shared constants, opcodes and the command and status types of the particle cell-list grid.
// Used by the controller, the datapath and the top level; depends on nothing else.
package pclg_pkg;

   localparam int MaxParticles = 1024;
   localparam int IdW          = 10;
   localparam int CellW        = 12;
   localparam int GridCells    = 4096;
   localparam int MaxN         = 16;
   localparam int CntW         = 11;
   localparam int CountLimit   = 2047;

   localparam logic [2:0] OP_CLEAR     = 3'd0;
   localparam logic [2:0] OP_INSERT    = 3'd1;
   localparam logic [2:0] OP_CONTACT   = 3'd2;
   localparam logic [2:0] OP_CLEARANCE = 3'd3;
   localparam logic [2:0] OP_COUNT     = 3'd4;

   localparam logic [1:0] CSR_CELLS     = 2'd0;
   localparam logic [1:0] CSR_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_CONTACT   = 2'd2;
   localparam logic [1:0] CSR_CLEARANCE = 2'd3;

   typedef struct packed {
      logic load;
      logic sweep;
      logic map_init;
      logic map_step;
      logic flat;
      logic ins_wr;
      logic ins_link;
      logic base;
      logic off_init;
      logic visit;
      logic head;
      logic link;
      logic sq_x;
      logic sq_y;
      logic sq_z;
      logic cmp;
      logic off_next;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       sweep_last;
      logic       sweep_full;
      logic       axis_fin;
      logic       axis_last;
      logic       head_ok;
      logic       link_ok;
      logic       dist_hit;
      logic       off_last;
      logic       rsp_busy;
   } sts_type;

endpackage

>>> src/pclg_ctrl.sv
// Controller state machine of the particle cell-list grid.
// Depends on pclg_pkg; drives the datapath only through cmd_type and reads sts_type.
module pclg_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  pclg_pkg::sts_type sts,
   output pclg_pkg::cmd_type cmd
);
   import pclg_pkg::*;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_DISPATCH = 5'd1;
   localparam logic [4:0] ST_SWEEP    = 5'd2;
   localparam logic [4:0] ST_MAP_INIT = 5'd3;
   localparam logic [4:0] ST_MAP_STEP = 5'd4;
   localparam logic [4:0] ST_FLAT     = 5'd5;
   localparam logic [4:0] ST_INS_RD   = 5'd6;
   localparam logic [4:0] ST_INS_WR   = 5'd7;
   localparam logic [4:0] ST_INS_LINK = 5'd8;
   localparam logic [4:0] ST_BASE     = 5'd9;
   localparam logic [4:0] ST_CELL     = 5'd10;
   localparam logic [4:0] ST_HEAD     = 5'd11;
   localparam logic [4:0] ST_NODE_RD  = 5'd12;
   localparam logic [4:0] ST_SQX      = 5'd13;
   localparam logic [4:0] ST_SQY      = 5'd14;
   localparam logic [4:0] ST_SQZ      = 5'd15;
   localparam logic [4:0] ST_CMP      = 5'd16;
   localparam logic [4:0] ST_CNT_LINK = 5'd17;
   localparam logic [4:0] ST_NEXT     = 5'd18;
   localparam logic [4:0] ST_DONE     = 5'd19;

   logic [4:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (sts.op)
               OP_CLEAR:                          state_in = ST_SWEEP;
               OP_INSERT, OP_CONTACT, OP_CLEARANCE: state_in = ST_MAP_INIT;
               OP_COUNT:                          state_in = ST_BASE;
               default:                           state_in = ST_DONE;
            endcase
         end
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_last) state_in = sts.sweep_full ? ST_IDLE : ST_DONE;
         end
         ST_MAP_INIT: begin
            cmd.map_init = 1'b1;
            state_in     = ST_MAP_STEP;
         end
         ST_MAP_STEP: begin
            cmd.map_step = 1'b1;
            if (sts.axis_fin) state_in = sts.axis_last ? ST_FLAT : ST_MAP_INIT;
         end
         ST_FLAT: begin
            cmd.flat     = 1'b1;
            cmd.off_init = 1'b1;
            state_in     = (sts.op == OP_INSERT) ? ST_INS_RD : ST_CELL;
         end
         ST_INS_RD:   state_in = ST_INS_WR;
         ST_INS_WR: begin
            cmd.ins_wr = 1'b1;
            state_in   = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            cmd.ins_link = 1'b1;
            state_in     = ST_DONE;
         end
         ST_BASE: begin
            cmd.base     = 1'b1;
            cmd.off_init = 1'b1;
            state_in     = ST_CELL;
         end
         ST_CELL: begin
            cmd.visit = 1'b1;
            state_in  = ST_HEAD;
         end
         ST_HEAD: begin
            if (sts.head_ok) begin
               cmd.head = 1'b1;
               state_in = ST_NODE_RD;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NODE_RD:  state_in = (sts.op == OP_COUNT) ? ST_CNT_LINK : ST_SQX;
         ST_SQX: begin
            cmd.sq_x = 1'b1;
            state_in = ST_SQY;
         end
         ST_SQY: begin
            cmd.sq_y = 1'b1;
            state_in = ST_SQZ;
         end
         ST_SQZ: begin
            cmd.sq_z = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (sts.dist_hit) begin
               cmd.cmp  = 1'b1;
               state_in = ST_DONE;
            end else if (sts.link_ok) begin
               cmd.link = 1'b1;
               state_in = ST_NODE_RD;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_CNT_LINK: begin
            if (sts.link_ok) begin
               cmd.link = 1'b1;
               state_in = ST_NODE_RD;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (sts.off_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.off_next = 1'b1;
               state_in     = ST_CELL;
            end
         end
         ST_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.done = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_SWEEP;
      else       state_ff <= state_in;
   end

endmodule

>>> src/pclg_dpath.sv
// Datapath of the particle cell-list grid: settings, list memories, cell mapping,
// distance unit, cube walk and result register. Depends on pclg_pkg.
module pclg_dpath (
   input  logic                          clock,
   input  logic                          reset,
   input  pclg_pkg::cmd_type             cmd,
   output pclg_pkg::sts_type             sts,
   input  logic [2:0]                    in_opcode,
   input  logic [pclg_pkg::IdW-1:0]      in_id,
   input  logic [31:0]                   in_x,
   input  logic [31:0]                   in_y,
   input  logic [31:0]                   in_z,
   input  logic [1:0]                    in_radius,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_index,
   input  logic [62:0]                   csr_wdata,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [pclg_pkg::CellW-1:0]    rsp_cell,
   output logic                          rsp_hit,
   output logic [pclg_pkg::IdW-1:0]      rsp_fid,
   output logic [pclg_pkg::CntW-1:0]     rsp_count
);
   import pclg_pkg::*;

   // Settings.
   logic [4:0]  cfg_n_ff;
   logic [30:0] cfg_w_ff;
   logic [62:0] cfg_contact_ff, cfg_clear_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_n_ff       <= 5'd16;
         cfg_w_ff       <= 31'd65536;
         cfg_contact_ff <= 63'h1_0000_0000;
         cfg_clear_ff   <= 63'h1_0000_0000;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CELLS:     cfg_n_ff       <= csr_wdata[4:0];
            CSR_WIDTH:     cfg_w_ff       <= csr_wdata[30:0];
            CSR_CONTACT:   cfg_contact_ff <= csr_wdata;
            CSR_CLEARANCE: cfg_clear_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [4:0]  n_eff;
   logic [30:0] w_eff;
   logic [3:0]  nm4;
   logic [8:0]  n2_in;
   logic [12:0] total_in;
   logic [34:0] m_in;

   assign n_eff    = (cfg_n_ff < 5'd5) ? 5'd5 :
                     (cfg_n_ff > 5'(MaxN)) ? 5'(MaxN) : cfg_n_ff;
   assign w_eff    = (cfg_w_ff == '0) ? 31'd1 : cfg_w_ff;
   assign nm4      = 4'(n_eff - 5'd4);
   assign n2_in    = 9'(n_eff) * 9'(n_eff);
   assign total_in = 13'(n2_in) * 13'(n_eff);
   assign m_in     = 35'(w_eff) * 35'(nm4);

   // Captured item and per-item constants.
   logic [2:0]       op_ff;
   logic [IdW-1:0]   id_ff;
   logic [31:0]      x_ff, y_ff, z_ff;
   logic [1:0]       r_ff;
   logic [4:0]       n_ff;
   logic [8:0]       n2_ff;
   logic [12:0]      total_ff;
   logic [34:0]      m_ff;
   logic [31:0]      w2_ff;
   logic [62:0]      thr_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= in_opcode;
         id_ff    <= in_id;
         x_ff     <= in_x;
         y_ff     <= in_y;
         z_ff     <= in_z;
         r_ff     <= in_radius;
         n_ff     <= n_eff;
         n2_ff    <= n2_in;
         total_ff <= total_in;
         m_ff     <= m_in;
         w2_ff    <= {w_eff, 1'b0};
         thr_ff   <= (in_opcode == OP_CONTACT) ? cfg_contact_ff : cfg_clear_ff;
      end
   end

   // Cell mapping, one axis at a time; the quotient is found by repeated subtraction.
   logic [1:0]  axis_ff;
   logic [36:0] t2_ff, acc_ff, t2_in, twom;
   logic [3:0]  q_ff, idx_in, ix_ff, iy_ff, iz_ff;
   logic [31:0] p_sel;
   logic        t2_neg, t2_gt, t2_ge, axis_fin;

   always_comb begin
      case (axis_ff)
         2'd0:    p_sel = x_ff;
         2'd1:    p_sel = y_ff;
         default: p_sel = z_ff;
      endcase
   end

   assign t2_in    = $signed({{4{p_sel[31]}}, p_sel, 1'b0}) + $signed({2'b00, m_ff});
   assign twom     = {1'b0, m_ff, 1'b0};
   assign t2_neg   = t2_ff[36];
   assign t2_gt    = $signed(t2_ff) > $signed(twom);
   assign t2_ge    = $signed(t2_ff) >= $signed(acc_ff);
   assign axis_fin = t2_neg | t2_gt | ~t2_ge;
   assign idx_in   = t2_neg ? 4'd1 : t2_gt ? 4'(n_ff - 5'd2) : 4'(q_ff + 4'd1);

   always_ff @(posedge clock) begin
      if (cmd.load) axis_ff <= 2'd0;
      if (cmd.map_init) begin
         t2_ff  <= t2_in;
         acc_ff <= {5'b0, w2_ff};
         q_ff   <= 4'd0;
      end
      if (cmd.map_step) begin
         if (axis_fin) begin
            case (axis_ff)
               2'd0:    ix_ff <= idx_in;
               2'd1:    iy_ff <= idx_in;
               default: iz_ff <= idx_in;
            endcase
            axis_ff <= 2'(axis_ff + 2'd1);
         end else begin
            q_ff   <= 4'(q_ff + 4'd1);
            acc_ff <= 37'(acc_ff + {5'b0, w2_ff});
         end
      end
   end

   logic [12:0] flat_sum;
   assign flat_sum = 13'(ix_ff) + 13'(iy_ff) * 13'(n_ff) + 13'(iz_ff) * 13'(n2_ff);

   // Memories.
   logic [IdW:0]     head_mem  [GridCells];
   logic [IdW-1:0]   tail_mem  [GridCells];
   logic [IdW:0]     link_mem  [MaxParticles];
   logic             ingr_mem  [MaxParticles];
   logic [CellW-1:0] pcell_mem [MaxParticles];
   logic [31:0]      sx_mem [MaxParticles];
   logic [31:0]      sy_mem [MaxParticles];
   logic [31:0]      sz_mem [MaxParticles];

   logic [IdW:0]     head_rd_ff, link_rd_ff;
   logic [IdW-1:0]   tail_rd_ff;
   logic             ingr_rd_ff;
   logic [CellW-1:0] pcell_rd_ff;
   logic [31:0]      sx_rd_ff, sy_rd_ff, sz_rd_ff;

   logic [CellW-1:0] cell_ff, sw_ff, head_addr;
   logic [IdW-1:0]   ptr_ff;
   logic             sweep_full_ff, ins_ok, sw_low;
   logic signed [2:0]  dx_ff, dy_ff, dz_ff;
   logic signed [14:0] cur_s;

   assign ins_ok    = ~ingr_rd_ff;
   assign sw_low    = (sw_ff[CellW-1:IdW] == '0);
   assign head_addr = (op_ff == OP_INSERT) ? cell_ff : cur_s[CellW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.sweep)
         head_mem[sw_ff] <= '0;
      else if (cmd.ins_wr && ins_ok && !head_rd_ff[IdW])
         head_mem[cell_ff] <= {1'b1, id_ff};
      head_rd_ff <= head_mem[head_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_wr && ins_ok) tail_mem[cell_ff] <= id_ff;
      tail_rd_ff <= tail_mem[cell_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_wr && ins_ok)
         link_mem[id_ff] <= '0;
      else if (cmd.ins_link && ins_ok && head_rd_ff[IdW])
         link_mem[tail_rd_ff] <= {1'b1, id_ff};
      link_rd_ff <= link_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep && sw_low)
         ingr_mem[sw_ff[IdW-1:0]] <= 1'b0;
      else if (cmd.ins_wr && ins_ok)
         ingr_mem[id_ff] <= 1'b1;
      ingr_rd_ff <= ingr_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep && sw_low && sweep_full_ff)
         pcell_mem[sw_ff[IdW-1:0]] <= '0;
      else if (cmd.ins_wr && ins_ok)
         pcell_mem[id_ff] <= cell_ff;
      pcell_rd_ff <= pcell_mem[id_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_wr && ins_ok) begin
         sx_mem[id_ff] <= x_ff;
         sy_mem[id_ff] <= y_ff;
         sz_mem[id_ff] <= z_ff;
      end
      sx_rd_ff <= sx_mem[ptr_ff];
      sy_rd_ff <= sy_mem[ptr_ff];
      sz_rd_ff <= sz_mem[ptr_ff];
   end

   // Clearing pass; the counter wraps back to zero at its end.
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff         <= '0;
         sweep_full_ff <= 1'b1;
      end else if (cmd.sweep) begin
         sw_ff <= 12'(sw_ff + 12'd1);
         if (sw_ff == '1) sweep_full_ff <= 1'b0;
      end
   end

   // Cube of neighbour cells.
   logic [1:0]        lim;
   logic signed [2:0] lim_s;
   logic              cur_ok, cur_ok_ff, off_last;

   assign lim      = (op_ff == OP_COUNT) ? r_ff : 2'd1;
   assign lim_s    = $signed({1'b0, lim});
   assign cur_s    = $signed({3'b000, cell_ff}) + 15'(dx_ff)
                     - 15'(dy_ff) * $signed({10'b0, n_ff})
                     - 15'(dz_ff) * $signed({6'b0, n2_ff});
   assign cur_ok   = (cur_s >= 0) && (cur_s < $signed({2'b00, total_ff}));
   assign off_last = (dx_ff == lim_s) && (dy_ff == lim_s) && (dz_ff == lim_s);

   always_ff @(posedge clock) begin
      if (cmd.off_init) begin
         dx_ff <= -lim_s;
         dy_ff <= -lim_s;
         dz_ff <= -lim_s;
      end else if (cmd.off_next) begin
         if (dx_ff != lim_s) begin
            dx_ff <= 3'(dx_ff + 3'sd1);
         end else begin
            dx_ff <= -lim_s;
            if (dy_ff != lim_s) begin
               dy_ff <= 3'(dy_ff + 3'sd1);
            end else begin
               dy_ff <= -lim_s;
               dz_ff <= 3'(dz_ff + 3'sd1);
            end
         end
      end
      if (cmd.visit) cur_ok_ff <= cur_ok;
   end

   // Squared distance, one axis a cycle through a single multiplier.
   logic [31:0] s_sel, q_sel, ad;
   logic [32:0] diff, ndiff;
   logic [63:0] sq_in, sq_ff, dacc_ff, dsum;
   logic [64:0] sum_w;
   logic        dist_hit;

   always_comb begin
      if (cmd.sq_y) begin
         s_sel = sy_rd_ff;
         q_sel = y_ff;
      end else if (cmd.sq_z) begin
         s_sel = sz_rd_ff;
         q_sel = z_ff;
      end else begin
         s_sel = sx_rd_ff;
         q_sel = x_ff;
      end
   end

   assign diff     = $signed({s_sel[31], s_sel}) - $signed({q_sel[31], q_sel});
   assign ndiff    = -diff;
   assign ad       = diff[32] ? ndiff[31:0] : diff[31:0];
   assign sq_in    = {32'b0, ad} * {32'b0, ad};
   assign sum_w    = {1'b0, dacc_ff} + {1'b0, sq_ff};
   assign dsum     = sum_w[64] ? '1 : sum_w[63:0];
   assign dist_hit = dsum < {1'b0, thr_ff};

   always_ff @(posedge clock) begin
      if (cmd.sq_x) begin
         sq_ff   <= sq_in;
         dacc_ff <= '0;
      end else if (cmd.sq_y || cmd.sq_z) begin
         sq_ff   <= sq_in;
         dacc_ff <= dsum;
      end
   end

   // Item results.
   logic           hit_ff;
   logic [IdW-1:0] fid_ff;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign cnt_in = (cnt_ff == CntW'(CountLimit)) ? cnt_ff : CntW'(cnt_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cell_ff <= '0;
         hit_ff  <= 1'b0;
         fid_ff  <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.flat) cell_ff <= flat_sum[CellW-1:0];
      if (cmd.base) cell_ff <= pcell_rd_ff;
      if (cmd.head) begin
         ptr_ff <= head_rd_ff[IdW-1:0];
         if (op_ff == OP_COUNT) cnt_ff <= cnt_in;
      end
      if (cmd.link) begin
         ptr_ff <= link_rd_ff[IdW-1:0];
         if (op_ff == OP_COUNT) cnt_ff <= cnt_in;
      end
      if (cmd.cmp && dist_hit) begin
         hit_ff <= 1'b1;
         fid_ff <= ptr_ff;
      end
   end

   // Output register.
   logic rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (cmd.done)  rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.done) begin
         rsp_cell  <= cell_ff;
         rsp_hit   <= hit_ff;
         rsp_fid   <= fid_ff;
         rsp_count <= cnt_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   assign sts.op         = op_ff;
   assign sts.sweep_last = (sw_ff == '1);
   assign sts.sweep_full = sweep_full_ff;
   assign sts.axis_fin   = axis_fin;
   assign sts.axis_last  = (axis_ff == 2'd2);
   assign sts.head_ok    = cur_ok_ff & head_rd_ff[IdW];
   assign sts.link_ok    = link_rd_ff[IdW];
   assign sts.dist_hit   = dist_hit;
   assign sts.off_last   = off_last;
   assign sts.rsp_busy   = rsp_valid_ff & ~rsp_ready;

endmodule

>>> src/particle_cell_list_grid.sv
// Top level of the particle cell-list grid: stream ports, field packing and the
// controller and datapath instances. Depends on pclg_pkg, pclg_ctrl and pclg_dpath.
//
// The block keeps a cubic grid of up to 16 cells a side in which each cell holds an
// ordered list of particles, and works on one request at a time. A clear empties every
// list by stepping through all 4096 list heads, one a cycle; the same clearing pass
// runs after reset, and no request is taken until it has finished (settings writes are
// taken throughout). Mapping a position to its cell works axis by axis through repeated
// subtraction of twice the cell width. A contact or clearance query visits the 27
// surrounding cells and examines the stored particles on their lists, the multiplier
// being shared by the three axes; it stops at the first particle closer than the
// threshold. A neighbour count visits up to 343 cells and walks the list of each, so
// its length is set by the list memory walk. A finished result waits in an output
// register, and the next request may be taken while it does.
module particle_cell_list_grid (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // opcode[2:0], id[12:3], pos_x[44:13], pos_y[76:45], pos_z[108:77],
   // search_radius[110:109], zero pad[111]
   input  logic [111:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // cell_index[11:0], hit[12], found_id[22:13], count[33:23], zero pad[39:34]
   output logic [39:0]   rsp_tdata,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [62:0]   csr_wdata
);
   import pclg_pkg::*;

   cmd_type cmd;
   sts_type sts;

   logic [CellW-1:0] rsp_cell;
   logic             rsp_hit;
   logic [IdW-1:0]   rsp_fid;
   logic [CntW-1:0]  rsp_count;

   pclg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pclg_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .in_opcode  (req_tdata[2:0]),
      .in_id      (req_tdata[12:3]),
      .in_x       (req_tdata[44:13]),
      .in_y       (req_tdata[76:45]),
      .in_z       (req_tdata[108:77]),
      .in_radius  (req_tdata[110:109]),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_cell   (rsp_cell),
      .rsp_hit    (rsp_hit),
      .rsp_fid    (rsp_fid),
      .rsp_count  (rsp_count)
   );

   // The result transfer carries the four fields packed from the lowest bit up.
   assign rsp_tdata = {6'b0, rsp_count, rsp_fid, rsp_hit, rsp_cell};

endmodule

>>> test/particle_cell_list_grid_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the particle cell-list grid: it watches the request, result and settings
// ports, predicts every result and compares it. Depends on pclg_pkg.
module particle_cell_list_grid_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [111:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [62:0]  csr_wdata,
   output int           fail_count,
   output int           outstanding
);
   import pclg_pkg::*;

   // Members run from the highest bits down, so cidx lands in the lowest bits.
   typedef struct packed {
      logic [10:0] count;
      logic [9:0]  found;
      logic        hit;
      logic [11:0] cidx;
   } grid_result_type;

   grid_result_type due_q[$];
   int              errors = 0;

   bit [4:0]  n_reg       = 5'd16;
   bit [30:0] w_reg       = 31'd65536;
   bit [62:0] contact_thr = 63'h1_0000_0000;
   bit [62:0] clear_thr   = 63'h1_0000_0000;

   bit        head_valid [GridCells];
   bit [9:0]  cell_head  [GridCells];
   bit [9:0]  cell_tail  [GridCells];
   bit        link_valid [MaxParticles];
   bit [9:0]  next_link  [MaxParticles];
   bit        in_grid    [MaxParticles];
   bit [11:0] home_cell  [MaxParticles];
   longint    px [MaxParticles];
   longint    py [MaxParticles];
   longint    pz [MaxParticles];

   initial begin
      foreach (head_valid[i]) head_valid[i] = 1'b0;
      foreach (in_grid[i]) begin
         in_grid[i]    = 1'b0;
         home_cell[i]  = '0;
         link_valid[i] = 1'b0;
      end
   end

   function automatic longint eff_n();
      return (n_reg < 5) ? 5 : ((n_reg > MaxN) ? MaxN : longint'(n_reg));
   endfunction

   function automatic longint eff_w();
      return (w_reg == 0) ? 1 : longint'(w_reg);
   endfunction

   function automatic longint axis_cell(longint p, longint n, longint w);
      longint m, t2;
      m  = w * (n - 4);
      t2 = 2 * p + m;
      if (t2 < 0) return 1;
      if (t2 > 2 * m) return n - 2;
      return 1 + t2 / (2 * w);
   endfunction

   function automatic longint cell_at(longint x, longint y, longint z);
      longint n, w;
      n = eff_n();
      w = eff_w();
      return axis_cell(x, n, w) + axis_cell(y, n, w) * n + axis_cell(z, n, w) * n * n;
   endfunction

   // The square wraps at 64 bits, exactly as an unsigned 64-bit product does.
   function automatic bit [63:0] sq_diff(longint a, longint b);
      longint    d;
      bit [63:0] ad;
      d  = a - b;
      ad = (d < 0) ? -d : d;
      return ad * ad;
   endfunction

   function automatic bit [63:0] sat_add(bit [63:0] a, bit [63:0] b);
      bit [64:0] s;
      s = {1'b0, a} + b;
      return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
   endfunction

   // Walks the 27 cells round centre, each list in insertion order, and stops at the
   // first particle strictly closer than the threshold.
   function automatic bit nearest_first(longint centre, longint x, longint y, longint z,
                                        bit [62:0] thr, output bit [9:0] found);
      longint    n, c;
      bit        ok;
      bit [9:0]  p;
      int        steps;
      bit [63:0] d;
      n     = eff_n();
      found = '0;
      for (int dz = -1; dz <= 1; dz++)
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
               c = centre + dx - dy * n - dz * n * n;
               if (c < 0 || c >= GridCells) continue;
               ok    = head_valid[c];
               p     = cell_head[c];
               steps = 0;
               while (ok && steps < MaxParticles) begin
                  d = sat_add(sat_add(sq_diff(px[p], x), sq_diff(py[p], y)),
                              sq_diff(pz[p], z));
                  if (d < {1'b0, thr}) begin
                     found = p;
                     return 1'b1;
                  end
                  ok = link_valid[p];
                  p  = next_link[p];
                  steps++;
               end
            end
      return 1'b0;
   endfunction

   function automatic int list_length(longint c);
      bit       ok;
      bit [9:0] p;
      int       len;
      ok  = head_valid[c];
      p   = cell_head[c];
      len = 0;
      while (ok && len < MaxParticles) begin
         len++;
         ok = link_valid[p];
         p  = next_link[p];
      end
      return len;
   endfunction

   // Updates the grid for one accepted request and queues the result it must give.
   task automatic predict(input logic [111:0] item);
      logic [2:0]      op;
      logic [9:0]      id;
      longint          x, y, z, c, n, base, s, cnt;
      grid_result_type r;
      op   = item[2:0];
      id   = item[12:3];
      x    = longint'($signed(item[44:13]));
      y    = longint'($signed(item[76:45]));
      z    = longint'($signed(item[108:77]));
      s    = longint'(item[110:109]);
      r    = '0;
      case (op)
         OP_CLEAR: begin
            foreach (head_valid[i]) head_valid[i] = 1'b0;
            foreach (in_grid[i]) in_grid[i] = 1'b0;
         end
         OP_INSERT: begin
            c      = cell_at(x, y, z);
            r.cidx = c[11:0];
            if (!in_grid[id]) begin
               in_grid[id]    = 1'b1;
               home_cell[id]  = c[11:0];
               px[id]         = x;
               py[id]         = y;
               pz[id]         = z;
               link_valid[id] = 1'b0;
               next_link[id]  = '0;
               if (head_valid[c]) begin
                  next_link[cell_tail[c]]  = id;
                  link_valid[cell_tail[c]] = 1'b1;
               end else begin
                  cell_head[c]  = id;
                  head_valid[c] = 1'b1;
               end
               cell_tail[c] = id;
            end
         end
         OP_CONTACT, OP_CLEARANCE: begin
            c      = cell_at(x, y, z);
            r.cidx = c[11:0];
            r.hit  = nearest_first(c, x, y, z, (op == OP_CONTACT) ? contact_thr : clear_thr,
                                   r.found);
         end
         OP_COUNT: begin
            n      = eff_n();
            base   = longint'(home_cell[id]);
            r.cidx = home_cell[id];
            cnt    = 0;
            for (longint dz = -s; dz <= s; dz++)
               for (longint dy = -s; dy <= s; dy++)
                  for (longint dx = -s; dx <= s; dx++) begin
                     c = base + dx - dy * n - dz * n * n;
                     if (c >= 0 && c < n * n * n) begin
                        cnt += list_length(c);
                        if (cnt > CountLimit) cnt = CountLimit;
                     end
                  end
            r.count = cnt[10:0];
         end
         default: ;
      endcase
      due_q = {due_q, r};
   endtask

   task automatic report(input string what, input longint got, input longint want);
      $display("%0t ns: result mismatch on %s: got %0d, expected %0d", $time, what,
               got, want);
      errors++;
   endtask

   always @(posedge clock) begin
      grid_result_type e, g;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_CELLS:     n_reg       = csr_wdata[4:0];
               CSR_WIDTH:     w_reg       = csr_wdata[30:0];
               CSR_CONTACT:   contact_thr = csr_wdata;
               CSR_CLEARANCE: clear_thr   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict(req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            g = rsp_tdata[33:0];
            if (due_q.size() == 0) begin
               report("unexpected transfer", g, 0);
            end else begin
               e = due_q.pop_front();
               if (g.cidx != e.cidx) report("cell_index", g.cidx, e.cidx);
               if (g.hit != e.hit) report("hit", g.hit, e.hit);
               if (g.found != e.found) report("found_id", g.found, e.found);
               if (g.count != e.count) report("count", g.count, e.count);
            end
         end
      end
      outstanding <= due_q.size();
      fail_count  <= errors;
   end

endmodule

>>> test/particle_cell_list_grid_tb.sv
`timescale 1ns / 1ps
// Top of the particle cell-list grid testbench: clock, reset, stimulus, settings and verdict.
// Depends on pclg_pkg, particle_cell_list_grid and particle_cell_list_grid_checker.
module particle_cell_list_grid_tb;
   import pclg_pkg::*;

   localparam longint Unit      = 65536;
   localparam int     IdleLimit = 300000;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [39:0]  rsp_tdata;
   logic         csr_we     = 1'b0;
   logic [1:0]   csr_index  = '0;
   logic [62:0]  csr_wdata  = '0;

   int fail_count, outstanding;

   // Mirror of the geometry settings, used only to aim positions at the grid.
   longint cfg_n = 16, cfg_w = Unit;

   // Recently inserted positions, reused with small offsets so that queries find hits.
   longint recent_x[16], recent_y[16], recent_z[16];
   int     recent_fill = 0;

   int n_items = 0, n_inserts = 0, n_queries = 0, n_counts = 0, n_settings = 1;
   int rsp_seen = 0, idle_cycles = 0;
   bit quiet = 1'b0, long_hold_done = 1'b0;

   particle_cell_list_grid uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   particle_cell_list_grid_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always #6 clock = ~clock;

   // The watchdog counts cycles in which no transfer happens on either channel. The limit
   // covers the clearing pass after reset, the longest list walks and the long hold-off.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (rsp_tvalid && rsp_tready) rsp_seen <= rsp_seen + 1;
      if (idle_cycles > IdleLimit) begin
         $display("Watchdog expired after %0d cycles without a transfer", IdleLimit);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side. It stalls in random bursts, and once, early on, it holds off for a long
   // stretch while requests keep coming, so the output register fills and the input stalls.
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (!long_hold_done && rsp_seen >= 40) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (500) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   // Offers one request and returns at the edge at which its transfer happens. A gap, if
   // any, is inserted before the request so that tvalid is only ever set once per edge.
   task automatic send(input logic [2:0] op, input logic [9:0] id, input longint x,
                       input longint y, input longint z, input logic [1:0] radius);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, radius, z[31:0], y[31:0], x[31:0], id, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      n_items++;
      case (op)
         OP_INSERT: begin
            n_inserts++;
            recent_x[recent_fill % 16] = x;
            recent_y[recent_fill % 16] = y;
            recent_z[recent_fill % 16] = z;
            recent_fill++;
         end
         OP_CONTACT, OP_CLEARANCE: n_queries++;
         OP_COUNT: n_counts++;
         default: ;
      endcase
   endtask

   // Positions are mostly within the grid span, sometimes near an earlier insert, and
   // sometimes fully random so that every bit of the fields toggles.
   function automatic longint pick_coord(int axis);
      longint n, w, span, near_w, origin;
      n = (cfg_n < 5) ? 5 : ((cfg_n > 16) ? 16 : cfg_n);
      w = (cfg_w == 0) ? 1 : cfg_w;
      span = w * (n - 4) / 2 + w;
      if (span > (64'd1 << 30)) span = 64'd1 << 30;
      if (recent_fill > 0 && $urandom_range(0, 2) == 0) begin
         near_w = (w > (64'd1 << 20)) ? (64'd1 << 20) : w;
         case (axis)
            0: origin = recent_x[$urandom_range(0, (recent_fill > 16 ? 16 : recent_fill) - 1)];
            1: origin = recent_y[$urandom_range(0, (recent_fill > 16 ? 16 : recent_fill) - 1)];
            default:
               origin = recent_z[$urandom_range(0, (recent_fill > 16 ? 16 : recent_fill) - 1)];
         endcase
         return origin + longint'($urandom_range(0, 2 * near_w)) - near_w;
      end
      if ($urandom_range(0, 7) == 0) return longint'($signed($urandom));
      return longint'($urandom_range(0, 2 * span)) - span;
   endfunction

   task automatic random_item();
      int         k;
      logic [2:0] op;
      logic [9:0] id;
      k  = $urandom_range(0, 99);
      id = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                       : 10'($urandom_range(0, 47));
      if (k < 2)       op = OP_CLEAR;
      else if (k < 45) op = OP_INSERT;
      else if (k < 63) op = OP_CONTACT;
      else if (k < 78) op = OP_CLEARANCE;
      else if (k < 96) op = OP_COUNT;
      else             op = 3'($urandom_range(5, 7));
      send(op, id, pick_coord(0), pick_coord(1), pick_coord(2), 2'($urandom_range(0, 3)));
   endtask

   // Withdraws the request and waits until every expected result has been seen, so the
   // block is idle.
   task automatic drain();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Writes all four settings on consecutive edges, while the block is idle.
   task automatic set_regs(input logic [4:0] n, input logic [30:0] w, input logic [62:0] c,
                           input logic [62:0] cl);
      req_tvalid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= i[1:0];
         case (i[1:0])
            CSR_CELLS:     csr_wdata <= {58'd0, n};
            CSR_WIDTH:     csr_wdata <= {32'd0, w};
            CSR_CONTACT:   csr_wdata <= c;
            CSR_CLEARANCE: csr_wdata <= cl;
            default: ;
         endcase
         @(posedge clock);
      end
      csr_we <= 1'b0;
      cfg_n  = n;
      cfg_w  = w;
      n_settings++;
   endtask

   function automatic logic [62:0] random_threshold();
      return 63'({$urandom, $urandom});
   endfunction

   initial begin
      longint      w;
      logic [62:0] max_thr;
      max_thr = '1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset settings: one cell is one unit, thresholds one unit.
      send(OP_INSERT, 10'd0, 0, 0, 0, 2'd0);
      send(OP_INSERT, 10'd0, 3 * Unit, 3 * Unit, 3 * Unit, 2'd0);    // repeated insert
      send(OP_INSERT, 10'd1, Unit / 2, 0, 0, 2'd0);
      send(OP_INSERT, 10'd2, Unit / 4, Unit / 4, 0, 2'd0);
      send(OP_CONTACT, 10'd5, Unit / 8, 0, 0, 2'd0);
      send(OP_CLEARANCE, 10'd0, 3 * Unit, 3 * Unit, 3 * Unit, 2'd3);
      // Positions at both ends of the range clamp into the inner border cells.
      send(OP_INSERT, 10'd1023, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 2'd3);
      send(OP_INSERT, 10'd1000, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 2'd0);
      send(OP_CONTACT, 10'd0, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 2'd0);
      send(OP_CLEARANCE, 10'd0, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 2'd0);
      send(OP_COUNT, 10'd0, 0, 0, 0, 2'd0);
      send(OP_COUNT, 10'd0, 0, 0, 0, 2'd3);
      send(OP_COUNT, 10'd1023, 0, 0, 0, 2'd1);
      send(OP_COUNT, 10'd1000, 0, 0, 0, 2'd3);
      send(OP_COUNT, 10'd77, 0, 0, 0, 2'd2);                    // never inserted
      send(3'd5, 10'd3, Unit, Unit, Unit, 2'd1);
      send(3'd6, 10'd1023, -1, -1, -1, 2'd3);
      send(3'd7, 10'd0, 0, 0, 0, 2'd0);
      send(OP_CLEAR, 10'd0, 0, 0, 0, 2'd0);
      send(OP_CONTACT, 10'd0, 0, 0, 0, 2'd0);                   // lists are empty again
      send(OP_COUNT, 10'd0, 0, 0, 0, 2'd3);
      send(OP_COUNT, 10'd1023, 0, 0, 0, 2'd0);                  // recorded cell survives
      send(OP_INSERT, 10'd0, Unit, Unit, Unit, 2'd0);           // re-insert after a clear
      repeat (150) random_item();

      // Smallest grid and cell width; no contact can be closer than zero, every
      // placement is too close.
      drain();
      set_regs(5'd5, 31'd1, 63'd0, max_thr);
      repeat (150) random_item();

      // Largest grid and widest cells; thresholds the other way round.
      drain();
      set_regs(5'd16, 31'h7FFF_FFFF, max_thr, 63'd0);
      repeat (150) random_item();

      // Settings below their legal range are saturated by the block.
      drain();
      set_regs(5'd0, 31'd0, 63'd4, random_threshold());
      repeat (150) random_item();

      // Settings above their legal range, quarter-unit cells.
      drain();
      w = Unit / 4;
      set_regs(5'd31, w[30:0], 63'(w * w), 63'(w * w / 4));
      repeat (150) random_item();

      // A random mid-range setting, with no idling on either side.
      drain();
      w = $urandom_range(4096, 262144);
      set_regs(5'($urandom_range(5, 16)), w[30:0], 63'(w * w * 2), 63'(w * w / 2));
      quiet = 1'b1;
      repeat (150) random_item();
      req_tvalid <= 1'b0;

      drain();
      repeat (50) @(posedge clock);
      $display("Covered %0d requests: %0d inserts, %0d queries, %0d neighbour counts,",
               n_items, n_inserts, n_queries, n_counts);
      $display("across %0d grid settings, with clears, unused opcodes and a long output stall.",
               n_settings);
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
